/* rtl/core/seven_segment_mux_driver_top_defines.svh */
// ----------------------------------------------------------------------------
// Seven-segment multiplexer assertion macros
// Shared macros for the concurrent checks of the display driver.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_MUX_DRIVER_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_MUX_DRIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define SSM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// When ante holds, cons holds at the same edge.
`define SSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// When ante holds, cons holds at the next edge.
`define SSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SSM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define SSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// Seven-segment multiplexer package
// Digit positions, select codes, segment table and shared types.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int ValueW = 16;
	localparam int PosW   = 2;
	localparam int DigitW = 4;
	localparam int PatW   = 8;

	localparam logic [PosW-1:0] POS_ONES     = 2'd0;
	localparam logic [PosW-1:0] POS_TENS     = 2'd1;
	localparam logic [PosW-1:0] POS_HUNDREDS = 2'd2;

	localparam logic [PatW-1:0] SEL_ONES     = 8'hFE;
	localparam logic [PatW-1:0] SEL_TENS     = 8'hFD;
	localparam logic [PatW-1:0] SEL_HUNDREDS = 8'hFB;

	// Reciprocal multipliers for exact division of any 16-bit value.
	localparam logic [15:0] RECIP_10   = 16'd52429;  // shift 19
	localparam logic [16:0] RECIP_100  = 17'd83887;  // shift 23
	localparam logic [16:0] RECIP_1000 = 17'd67109;  // shift 26

	// One input word held in the input register.
	typedef struct packed {
		logic valid;
		logic tick;
	} item_t;

	function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] pos);
		logic [PosW-1:0] res;
		case (pos)
			POS_ONES: res = POS_TENS;
			POS_TENS: res = POS_HUNDREDS;
			default:  res = POS_ONES;
		endcase
		return res;
	endfunction

	function automatic logic [PatW-1:0] sel_of(input logic [PosW-1:0] pos);
		logic [PatW-1:0] res;
		case (pos)
			POS_ONES: res = SEL_ONES;
			POS_TENS: res = SEL_TENS;
			default:  res = SEL_HUNDREDS;
		endcase
		return res;
	endfunction

	function automatic logic [PatW-1:0] seg_of(input logic [DigitW-1:0] digit);
		logic [PatW-1:0] res;
		case (digit)
			4'd0:    res = 8'h03;
			4'd1:    res = 8'hF3;
			4'd2:    res = 8'h25;
			4'd3:    res = 8'h0D;
			4'd4:    res = 8'h99;
			4'd5:    res = 8'h49;
			4'd6:    res = 8'h41;
			4'd7:    res = 8'h1F;
			4'd8:    res = 8'h01;
			4'd9:    res = 8'h19;
			default: res = 8'hFF;
		endcase
		return res;
	endfunction

endpackage

/* rtl/core/ssm_in_stage.sv */
// ----------------------------------------------------------------------------
// Seven-segment multiplexer input stage
// Registers the incoming refresh word and stalls the source when full.
// ----------------------------------------------------------------------------
module ssm_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           refresh_tick,
	input  logic           take,
	output ssm_pkg::item_t item
);
	import ssm_pkg::*;

	item_t item_s1;

	// The register frees up in the same cycle the next stage takes its word.
	assign in_stall = item_s1.valid && !take;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (!in_stall) begin
			item_s1.valid <= in_valid;
			item_s1.tick  <= refresh_tick;
		end
	end

endmodule

/* rtl/core/ssm_digit_ext.sv */
// ----------------------------------------------------------------------------
// Seven-segment multiplexer digit extractor
// Picks the ones, tens or hundreds decimal digit of a 16-bit value.
// ----------------------------------------------------------------------------
module ssm_digit_ext (
	input  logic [ssm_pkg::ValueW-1:0] value,
	input  logic [ssm_pkg::PosW-1:0]   pos,
	output logic [ssm_pkg::DigitW-1:0] digit
);
	import ssm_pkg::*;

	logic [31:0] prod10;
	logic [32:0] prod100;
	logic [32:0] prod1000;
	logic [12:0] q10;
	logic [9:0]  q100;
	logic [6:0]  q1000;
	logic [15:0] rem_ones;
	logic [12:0] rem_tens;
	logic [9:0]  rem_hundreds;

	// The three quotients come from independent constant multiplies.
	assign prod10   = value * RECIP_10;
	assign prod100  = value * RECIP_100;
	assign prod1000 = value * RECIP_1000;

	assign q10   = prod10[31:19];
	assign q100  = prod100[32:23];
	assign q1000 = prod1000[32:26];

	// Each digit is a quotient less ten times the next quotient.
	assign rem_ones     = value - ({q10, 3'b000} + {2'b00, q10, 1'b0});
	assign rem_tens     = q10 - ({q100, 3'b000} + {2'b00, q100, 1'b0});
	assign rem_hundreds = q100 - ({q1000, 3'b000} + {2'b00, q1000, 1'b0});

	always_comb begin
		case (pos)
			POS_ONES: digit = rem_ones[DigitW-1:0];
			POS_TENS: digit = rem_tens[DigitW-1:0];
			default:  digit = rem_hundreds[DigitW-1:0];
		endcase
	end

endmodule

/* rtl/core/seven_segment_mux_driver_top.sv */
// ----------------------------------------------------------------------------
// Seven-segment multiplexer driver, top level
// Three-digit common-anode display driver with active-low outputs.
// ----------------------------------------------------------------------------
// Every input word yields one output word: the digit position steps ones,
// tens, hundreds when refresh_tick is set and holds otherwise, and the
// output carries the active-low select and segment patterns of that digit
// of the displayed number (only the lowest three decimal digits are shown).
// One word is taken per clock while the output is not stalled; a word is written
// into the input register at the edge that accepts it and then into the output
// register once that register can take it, with the constant-reciprocal
// digit split and segment lookup in between. The displayed number is written
// by the user through cfg_wr_en and cfg_wr_data while no word is in flight
// (not enforced by the block) and resets to zero, as does the digit position.
module seven_segment_mux_driver_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ssm_pkg::ValueW-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       refresh_tick,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ssm_pkg::PatW-1:0]   digit_select,
	output logic [ssm_pkg::PatW-1:0]   segment_pattern
);
	import ssm_pkg::*;

	`include "seven_segment_mux_driver_top_defines.svh"

	item_t             item;
	logic              take;
	logic              load;
	logic [PosW-1:0]   pos_q;
	logic [PosW-1:0]   pos_next;
	logic [ValueW-1:0] number_q;
	logic [DigitW-1:0] digit;
	logic              out_valid_q;
	logic [PatW-1:0]   digit_select_q;
	logic [PatW-1:0]   segment_pattern_q;

	// The output register can take a word when empty or being drained.
	assign take = !out_valid_q || !out_stall;
	assign load = item.valid && take;

	assign pos_next = item.tick ? next_pos(pos_q) : pos_q;

	ssm_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.refresh_tick (refresh_tick),
		.take         (take),
		.item         (item)
	);

	ssm_digit_ext u_digit_ext (
		.value (number_q),
		.pos   (pos_next),
		.digit (digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_q <= '0;
		end else if (cfg_wr_en) begin
			number_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_ONES;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= item.valid;
			end
			if (load) begin
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digit_select_q    <= sel_of(pos_next);
			segment_pattern_q <= seg_of(digit);
		end
	end

	assign out_valid       = out_valid_q;
	assign digit_select    = digit_select_q;
	assign segment_pattern = segment_pattern_q;

	`SSM_ASSERT_ALWAYS(a_pos_reachable, clk, arst_n,
		(pos_q == POS_ONES) || (pos_q == POS_TENS) || (pos_q == POS_HUNDREDS),
		"digit position reached the unused code")
	`SSM_ASSERT_SAME(a_sel_matches_pos, clk, arst_n, out_valid_q,
		digit_select_q == sel_of(pos_q), "output select does not match the digit position")
	`SSM_ASSERT_NEXT(a_pos_only_on_load, clk, arst_n, !load,
		pos_q == $past(pos_q), "digit position moved without a word")
	`SSM_ASSERT_NEXT(a_accept_fills_stage, clk, arst_n, in_valid && !in_stall,
		item.valid, "accepted word did not reach the input register")
	`SSM_ASSERT_NEXT(a_load_fills_output, clk, arst_n, load,
		out_valid_q, "processed word did not reach the output register")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment multiplexer driver testbench
// Drives refresh words with random gaps and output stalls, predicts the
// select and segment drive of each word and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
	import ssm_pkg::*;

	typedef struct packed {
		logic [PatW-1:0] sel;
		logic [PatW-1:0] seg;
	} drive_t;

	// Active-low segment codes for the decimal digits 0 to 9, digit 0 lowest.
	localparam logic [10*PatW-1:0] SEG_CODES = {
		8'h19, 8'h01, 8'h1F, 8'h41, 8'h49, 8'h99, 8'h0D, 8'h25, 8'hF3, 8'h03
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [ValueW-1:0] cfg_wr_data;
	logic              in_valid;
	logic              in_stall;
	logic              refresh_tick;
	logic              out_valid;
	logic              out_stall;
	logic [PatW-1:0]   digit_select;
	logic [PatW-1:0]   segment_pattern;

	logic [PosW-1:0]   shown_pos;
	logic [ValueW-1:0] shown_value;
	drive_t            pending_drive[$];
	bit                no_idle;
	int                hold_cycles;
	int                stall_left;
	int                frames_checked = 0;
	int                values_written = 0;
	int                drive_errors = 0;

	seven_segment_mux_driver_top u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.refresh_tick    (refresh_tick),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.digit_select    (digit_select),
		.segment_pattern (segment_pattern)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout at %0t with %0d words outstanding.", $time, pending_drive.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	function automatic drive_t predict_drive(input logic [PosW-1:0] pos,
			input logic [ValueW-1:0] value);
		drive_t d;
		int     digit;
		case (pos)
			POS_ONES: begin
				digit = value % 10;
				d.sel = SEL_ONES;
			end
			POS_TENS: begin
				digit = (value / 10) % 10;
				d.sel = SEL_TENS;
			end
			default: begin
				digit = (value / 100) % 10;
				d.sel = SEL_HUNDREDS;
			end
		endcase
		d.seg = SEG_CODES[digit*PatW +: PatW];
		return d;
	endfunction

	// Receiver side: a requested hold-off takes priority over random stalls.
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles = hold_cycles - 1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left = stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		drive_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drive.size() == 0) begin
				$display("%0t: unexpected word sel=%h seg=%h", $time,
					digit_select, segment_pattern);
				drive_errors++;
			end else begin
				want = pending_drive.pop_front();
				frames_checked++;
				if (digit_select !== want.sel) begin
					$display("%0t: digit_select expected %h actual %h", $time,
						want.sel, digit_select);
					drive_errors++;
				end
				if (segment_pattern !== want.seg) begin
					$display("%0t: segment_pattern expected %h actual %h", $time,
						want.seg, segment_pattern);
					drive_errors++;
				end
			end
		end
	end

	// All tasks below start and end at a falling edge.
	task automatic send_tick(input logic tick);
		int gap;
		in_valid <= 1'b1;
		refresh_tick <= tick;
		do
			@(posedge clk);
		while (in_stall);
		if (tick) begin
			case (shown_pos)
				POS_ONES: shown_pos = POS_TENS;
				POS_TENS: shown_pos = POS_HUNDREDS;
				default:  shown_pos = POS_ONES;
			endcase
		end
		pending_drive.push_back(predict_drive(shown_pos, shown_value));
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_display_idle();
		in_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_number(input logic [ValueW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		shown_value = value;
		values_written++;
	endtask

	// Straight after reset a held step shows the ones digit of zero.
	task automatic test_reset_state();
		send_tick(1'b0);
		wait_display_idle();
	endtask

	// Each value starts with a held step so the new digit shows at once,
	// then walks all three positions. Together the values use every digit,
	// and 1000 and 65535 check that higher digits are dropped.
	task automatic test_digit_table();
		logic [ValueW-1:0] values [5];
		values = '{16'd987, 16'd654, 16'd321, 16'd1000, 16'd65535};
		foreach (values[i]) begin
			write_number(values[i]);
			send_tick(1'b0);
			repeat (3) send_tick(1'b1);
			wait_display_idle();
		end
	endtask

	task automatic test_random_ticks();
		logic [ValueW-1:0] value;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0:       value = '0;
				1:       value = '1;
				default: value = ($urandom_range(0, 1) != 0)
					? ValueW'($urandom_range(0, 999))
					: ValueW'($urandom_range(0, 65535));
			endcase
			no_idle = (phase == 3);
			write_number(value);
			repeat (50) send_tick($urandom_range(0, 9) < 7);
			wait_display_idle();
		end
		no_idle = 1'b0;
	endtask

	// The receiver holds off long enough for the block to fill and stall its
	// input while words keep coming; then the sender waits for every word.
	task automatic test_output_hold_off();
		write_number(ValueW'($urandom_range(100, 999)));
		hold_cycles = 60;
		no_idle = 1'b1;
		repeat (30) send_tick($urandom_range(0, 1) != 0);
		no_idle = 1'b0;
		wait_display_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		refresh_tick = 1'b0;
		no_idle = 1'b0;
		hold_cycles = 0;
		shown_pos = POS_ONES;
		shown_value = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_digit_table();
		test_random_ticks();
		test_output_hold_off();
		wait_display_idle();

		$display("Checked %0d display words across %0d display values, with tick and hold",
			frames_checked, values_written);
		$display("steps, all three digit positions, random gaps and a long output hold-off.");
		if (drive_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* seven_segment_mux_driver_top.f */
+incdir+rtl/core
rtl/core/ssm_pkg.sv
rtl/core/ssm_in_stage.sv
rtl/core/ssm_digit_ext.sv
rtl/core/seven_segment_mux_driver_top.sv
bench/testbench.sv
